FILE: design/ndp_pkg.sv
// shared types and constants for the nat port delta predictor
// no dependencies; every other design file but ndp_divider refers to this package by scoped names
`default_nettype none

package ndp_pkg;

   localparam int PORT_W      = 16;
   localparam int ENTRY_W     = 2 * PORT_W;
   localparam int MIN_ENTRIES = 2;

   // request function codes
   localparam logic FUNC_RECORD  = 1'b0;
   localparam logic FUNC_PREDICT = 1'b1;

   typedef struct packed {
      logic [PORT_W-1:0] priv;
      logic [PORT_W-1:0] pub;
   } ndp_entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIVIDE,
      ST_RESULT
   } ndp_state_type;

endpackage

`default_nettype wire

FILE: design/ndp_if.sv
// valid/ready channel interfaces for request and response words
// depends on ndp_pkg for the port width
`default_nettype none

interface ndp_req_if;
   logic                       valid;
   logic                       ready;
   logic                       func;
   logic [ndp_pkg::PORT_W-1:0] lan_port;
   logic [ndp_pkg::PORT_W-1:0] wan_port;

   modport source (output valid, func, lan_port, wan_port, input ready);
   modport sink   (input valid, func, lan_port, wan_port, output ready);
endinterface

interface ndp_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [ndp_pkg::PORT_W-1:0] pred_port;

   modport source (output valid, pred_port, input ready);
   modport sink   (input valid, pred_port, output ready);
endinterface

`default_nettype wire

FILE: design/ndp_history_mem.sv
// history table: single write port, single read port, registered read
// depends on ndp_pkg for the entry width
`default_nettype none

module ndp_history_mem #(
   parameter int DEPTH  = 128,
   parameter int ADDR_W = 7
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [ADDR_W-1:0]           wr_addr,
   input  wire logic [ndp_pkg::ENTRY_W-1:0] wr_data,
   input  wire logic                        rd_en,
   input  wire logic [ADDR_W-1:0]           rd_addr,
   output logic      [ndp_pkg::ENTRY_W-1:0] rd_data
);

   logic [ndp_pkg::ENTRY_W-1:0] mem_ff [DEPTH];
   logic [ndp_pkg::ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/ndp_divider.sv
// unsigned restoring divider, one quotient bit per cycle
// no package dependencies
`default_nettype none

module ndp_divider #(
   parameter int DVD_W = 23,
   parameter int DVS_W = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output logic                  done,
   output logic      [DVD_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DVD_W + 1);

   logic              active_ff, active_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DVS_W:0]    rem_shift;
   logic              ge;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[DVD_W-1]};
      ge        = rem_shift >= {1'b0, dvs_ff};
      active_in = active_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      if (start) begin
         active_in = 1'b1;
         step_in   = '0;
         quo_in    = dividend;
         rem_in    = '0;
         dvs_in    = divisor;
      end else if (active_ff) begin
         // dividend bits shift out the top while quotient bits enter the bottom
         quo_in  = {quo_ff[DVD_W-2:0], ge};
         rem_in  = ge ? DVS_W'(rem_shift - {1'b0, dvs_ff}) : rem_shift[DVS_W-1:0];
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DVD_W - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

FILE: design/nat_port_delta_predictor_unit.sv
// top level of the nat port delta predictor: control, scan datapath, response register
// depends on ndp_pkg, ndp_req_if, ndp_rsp_if, ndp_history_mem and ndp_divider
//
//   channel  | dir | handshake           | word
//   ---------+-----+---------------------+--------------------------------------
//   req_chan | in  | valid/ready         | func, lan_port, wan_port
//   rsp_chan | out | valid/ready         | pred_port (predict words only)
//
// a record word is accepted back to back
// a predict word scans the history one entry per memory read, then the serial divider
// averages the matched deltas unless nothing matched, then the result is loaded;
// with fewer than two entries it goes straight to the result state
// reset is synchronous and clears control state and the entry count; the table is not cleared
// a result waits in the response register while the next word is accepted; a later
// prediction holds in its result state until that register is taken
`default_nettype none

module nat_port_delta_predictor_unit #(
   parameter int HISTORY_DEPTH = 128
) (
   input wire logic clock,
   input wire logic reset,
   ndp_req_if.sink   req_chan,
   ndp_rsp_if.source rsp_chan
);

   localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
   // a delta spans 17 signed bits; up to HISTORY_DEPTH-1 of them are summed
   localparam int SUM_W = ndp_pkg::PORT_W + 1 + IDX_W;
   localparam int DVD_W = SUM_W - 1;
   localparam int PW    = ndp_pkg::PORT_W;

   // fsm
   ndp_pkg::ndp_state_type state_ff, state_in;

   // control outputs of the fsm
   logic req_ready;
   logic rd_issue;
   logic div_start;
   logic rsp_load;

   // table bookkeeping
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] scan_addr_ff;
   logic             rd_vld_ff;
   logic [IDX_W-1:0] rd_idx_ff;

   // scan accumulators
   logic        [PW-1:0]    query_ff;
   logic        [PW-1:0]    prev_pub_ff;
   logic        [PW-1:0]    last_pub_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic        [CNT_W-1:0] match_ff;
   logic                    neg_ff;
   logic        [PW-1:0]    res_ff;

   // response register
   logic          rsp_valid_ff;
   logic [PW-1:0] rsp_port_ff;

   // combinational datapath
   logic                        accept;
   logic                        is_predict;
   logic                        table_full;
   logic                        short_history;
   logic [ndp_pkg::ENTRY_W-1:0] rd_data;
   ndp_pkg::ndp_entry_type      rd_entry;
   ndp_pkg::ndp_entry_type      wr_entry;
   logic signed [PW:0]          delta;
   logic                        hit;
   logic                        last_beat;
   logic signed [SUM_W-1:0]     sum_next;
   logic        [CNT_W-1:0]     match_next;
   logic signed [SUM_W-1:0]     sum_abs;
   logic        [DVD_W-1:0]     quotient;
   logic                        div_done;
   logic        [PW-1:0]        avg_lo;

   assign accept        = req_chan.valid && req_ready;
   assign is_predict    = req_chan.func == ndp_pkg::FUNC_PREDICT;
   assign table_full    = count_ff >= CNT_W'(HISTORY_DEPTH);
   assign short_history = count_ff < CNT_W'(ndp_pkg::MIN_ENTRIES);

   assign wr_entry.priv = req_chan.lan_port;
   assign wr_entry.pub  = req_chan.wan_port;

   ndp_history_mem #(
      .DEPTH  (HISTORY_DEPTH),
      .ADDR_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (accept && !is_predict && !table_full),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_entry),
      .rd_en   (rd_issue),
      .rd_addr (scan_addr_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // one read returns per cycle; entry 0 only primes the previous public port
   always_comb begin
      rd_entry   = ndp_pkg::ndp_entry_type'(rd_data);
      delta      = $signed({1'b0, rd_entry.pub}) - $signed({1'b0, prev_pub_ff});
      hit        = rd_vld_ff && (rd_idx_ff != '0) && (rd_entry.priv == query_ff);
      last_beat  = rd_vld_ff && (CNT_W'(rd_idx_ff) == count_ff - CNT_W'(1));
      sum_next   = hit ? sum_ff + SUM_W'(delta) : sum_ff;
      match_next = hit ? match_ff + CNT_W'(1) : match_ff;
      sum_abs    = sum_next[SUM_W-1] ? -sum_next : sum_next;
   end

   ndp_divider #(
      .DVD_W (DVD_W),
      .DVS_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_abs[DVD_W-1:0]),
      .divisor  (match_next),
      .done     (div_done),
      .quotient (quotient)
   );

   // truncation toward zero: divide magnitudes, then restore the sign; only the
   // low port bits matter since the final add wraps modulo 65536
   assign avg_lo = neg_ff ? PW'(-quotient[PW-1:0]) : quotient[PW-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ndp_pkg::ST_IDLE: begin
            if (accept && is_predict) begin
               state_in = short_history ? ndp_pkg::ST_RESULT : ndp_pkg::ST_SCAN;
            end
         end
         ndp_pkg::ST_SCAN: begin
            if (last_beat) begin
               state_in = (match_next == '0) ? ndp_pkg::ST_RESULT : ndp_pkg::ST_DIVIDE;
            end
         end
         ndp_pkg::ST_DIVIDE: begin
            if (div_done) begin
               state_in = ndp_pkg::ST_RESULT;
            end
         end
         ndp_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in = ndp_pkg::ST_IDLE;
            end
         end
         default: state_in = ndp_pkg::ST_IDLE;
      endcase
   end

   // fsm outputs
   always_comb begin
      req_ready = 1'b0;
      rd_issue  = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ndp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         ndp_pkg::ST_SCAN: begin
            rd_issue  = scan_addr_ff < count_ff;
            div_start = last_beat && (match_next != '0);
         end
         ndp_pkg::ST_DIVIDE: begin
         end
         ndp_pkg::ST_RESULT: begin
            rsp_load = !rsp_valid_ff || rsp_chan.ready;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ndp_pkg::ST_IDLE;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_issue;
         // append only; records beyond the last entry are dropped
         if (accept && !is_predict && !table_full) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // scan and result datapath
   always_ff @(posedge clock) begin
      if (accept && is_predict) begin
         query_ff     <= req_chan.lan_port;
         scan_addr_ff <= '0;
         sum_ff       <= '0;
         match_ff     <= '0;
         res_ff       <= '0;
      end else if (rd_issue) begin
         scan_addr_ff <= scan_addr_ff + CNT_W'(1);
      end
      if (rd_issue) begin
         rd_idx_ff <= scan_addr_ff[IDX_W-1:0];
      end
      if (rd_vld_ff) begin
         prev_pub_ff <= rd_entry.pub;
         sum_ff      <= sum_next;
         match_ff    <= match_next;
         neg_ff      <= sum_next[SUM_W-1];
         if (last_beat) begin
            last_pub_ff <= rd_entry.pub;
         end
      end
      if (div_done) begin
         res_ff <= last_pub_ff + avg_lo;
      end
      if (rsp_load) begin
         rsp_port_ff <= res_ff;
      end
   end

   assign req_chan.ready     = req_ready;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.pred_port = rsp_port_ff;

endmodule

`default_nettype wire

FILE: design/ndp_checker.sv
// port level checks for the nat port delta predictor, bound to the top level
// depends on ndp_pkg for the function codes
`default_nettype none

module ndp_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       req_func,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic [ndp_pkg::PORT_W-1:0] rsp_pred_port
);

   // a pending response word is not withdrawn
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response valid dropped while stalled");

   // a stalled response word keeps its port
   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_pred_port))
      else $error("response port changed while stalled");

   // after a record word the input is ready again in the next cycle
   a_record_fast : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_func == ndp_pkg::FUNC_RECORD) |=> req_ready)
      else $error("input stalled after a record word");

   // after a predict word the input is not ready in the next cycle
   a_predict_busy : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_func == ndp_pkg::FUNC_PREDICT) |=> !req_ready)
      else $error("input ready right after a predict word");

   // no response word straight out of reset
   a_reset_quiet : assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind nat_port_delta_predictor_unit ndp_checker u_ndp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .req_func      (req_chan.func),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_pred_port (rsp_chan.pred_port)
);

`default_nettype wire

FILE: bench/ndp_forecast_checker.sv
// checker for the nat port delta predictor: watches the request and response words,
// keeps its own mapping history and compares each predicted port in order
// depends on ndp_pkg for the entry layout, function codes and minimum history
`timescale 1ns / 100ps

module ndp_forecast_checker #(
   parameter int HISTORY_DEPTH = 128,
   parameter int REPORT_MAX    = 10
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic        req_func,
   input  wire logic [15:0] req_lan_port,
   input  wire logic [15:0] req_wan_port,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [15:0] rsp_pred_port,
   output int               fail_count,
   output int               pending_count
);

   ndp_pkg::ndp_entry_type map_table [HISTORY_DEPTH];
   int unsigned            map_count;
   logic [15:0]            port_forecast_q [$];
   int                     faults;

   // mean public-port step over matching entries, added to the newest public port
   function automatic logic [15:0] forecast_port(input logic [15:0] query);
      longint      delta_sum;
      longint      mean_step;
      int unsigned hits;
      int unsigned idx;
      logic [15:0] last_pub;
      delta_sum = 0;
      hits      = 0;
      if (map_count < ndp_pkg::MIN_ENTRIES) return '0;
      for (idx = 1; idx < map_count; idx++) begin
         if (map_table[idx].priv == query) begin
            delta_sum += longint'(map_table[idx].pub) - longint'(map_table[idx-1].pub);
            hits++;
         end
      end
      if (hits == 0) return '0;
      // signed division truncates toward zero
      mean_step = delta_sum / longint'(hits);
      last_pub  = map_table[map_count-1].pub;
      return last_pub + mean_step[15:0];
   endfunction

   task automatic report_fault(input string msg);
      faults++;
      if (faults <= REPORT_MAX) $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      logic [15:0] want;
      if (reset) begin
         map_count = 0;
         faults    = 0;
         port_forecast_q.delete();
      end else begin
         if (req_valid && req_ready) begin
            if (req_func == ndp_pkg::FUNC_PREDICT) begin
               port_forecast_q.push_back(forecast_port(req_lan_port));
            end else if (map_count < HISTORY_DEPTH) begin
               map_table[map_count] = '{priv: req_lan_port, pub: req_wan_port};
               map_count++;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (port_forecast_q.size() == 0) begin
               report_fault($sformatf("unexpected word, pred_port %0d",
                                      rsp_pred_port));
            end else begin
               want = port_forecast_q.pop_front();
               if (rsp_pred_port !== want)
                  report_fault($sformatf("pred_port expected %0d actual %0d",
                                         want, rsp_pred_port));
            end
         end
      end
      fail_count    <= faults;
      pending_count <= port_forecast_q.size();
   end

endmodule

FILE: bench/nat_port_delta_predictor_unit_tb.sv
// testbench top for the nat port delta predictor: clock, reset, request stimulus,
// response back-pressure, watchdog and verdict; checking lives in ndp_forecast_checker
// depends on ndp_pkg, ndp_req_if, ndp_rsp_if, the block and ndp_forecast_checker
`timescale 1ns / 100ps

module nat_port_delta_predictor_unit_tb;

   localparam int HISTORY_DEPTH = 128;
   localparam int RANDOM_ITEMS  = 430;
   // allow for a full-table prediction plus long stalls on both sides
   localparam int STALL_LIMIT   = 4000;
   localparam int DRAIN_CYCLES  = 300;

   logic clock;
   logic reset;

   ndp_req_if req_bus ();
   ndp_rsp_if rsp_bus ();

   int fail_count;
   int pending_count;

   // idling mix, in percent per cycle
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;

   // bench-side bookkeeping for stimulus shaping only
   int unsigned recorded;
   int unsigned counted;
   int unsigned quiet_cycles;
   logic [15:0] last_pub;
   logic [15:0] priv_pool [6];

   nat_port_delta_predictor_unit #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   ndp_forecast_checker #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_ready     (req_bus.ready),
      .req_func      (req_bus.func),
      .req_lan_port  (req_bus.lan_port),
      .req_wan_port  (req_bus.wan_port),
      .rsp_valid     (rsp_bus.valid),
      .rsp_ready     (rsp_bus.ready),
      .rsp_pred_port (rsp_bus.pred_port),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // response back-pressure, redrawn every cycle
   initial rsp_bus.ready = 1'b0;
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog: cycles in which neither channel moves a word
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // present one word, with optional idle cycles ahead of it, and wait for acceptance
   task automatic issue_word(input logic func, input logic [15:0] priv,
                             input logic [15:0] pub);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.func     <= func;
      req_bus.lan_port <= priv;
      req_bus.wan_port <= pub;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      // records past a full table are dropped by the block and not counted
      if (func == ndp_pkg::FUNC_PREDICT) begin
         counted++;
      end else if (recorded < HISTORY_DEPTH) begin
         recorded++;
         last_pub = pub;
         counted++;
      end
   endtask

   // one random word: mostly records into a small set of private ports while the
   // table fills, then mostly predictions with a few records that hit the full table
   task automatic random_word();
      logic        do_record;
      logic [15:0] priv;
      logic [15:0] pub;
      if (recorded < HISTORY_DEPTH) do_record = ($urandom_range(99) < 55);
      else                          do_record = ($urandom_range(99) < 6);
      if ($urandom_range(99) < 78) priv = priv_pool[$urandom_range(5)];
      else                         priv = 16'($urandom);
      if (do_record) begin
         // small steps around the last public port, like a real nat, plus wild jumps
         if ($urandom_range(99) < 60) pub = last_pub + 16'($urandom_range(40)) - 16'd20;
         else                         pub = 16'($urandom);
         issue_word(ndp_pkg::FUNC_RECORD, priv, pub);
      end else begin
         issue_word(ndp_pkg::FUNC_PREDICT, priv, 16'($urandom));
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.func     = ndp_pkg::FUNC_RECORD;
      req_bus.lan_port = '0;
      req_bus.wan_port = '0;
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      recorded         = 0;
      counted          = 0;
      quiet_cycles     = 0;
      last_pub         = '0;
      foreach (priv_pool[k]) priv_pool[k] = 16'($urandom);
      priv_pool[0] = 16'd0;
      priv_pool[1] = 16'hFFFF;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty and single-entry history answer zero
      issue_word(ndp_pkg::FUNC_PREDICT, 16'd0, 16'hFFFF);
      issue_word(ndp_pkg::FUNC_RECORD, 16'hFFFF, 16'h0000);
      issue_word(ndp_pkg::FUNC_PREDICT, 16'hFFFF, 16'h0000);
      // one match: 0 -> 100, prediction 200
      issue_word(ndp_pkg::FUNC_RECORD, 16'd5, 16'd100);
      issue_word(ndp_pkg::FUNC_PREDICT, 16'd5, 16'hFFFF);
      // entry 0 is never compared, so its private port finds no match
      issue_word(ndp_pkg::FUNC_PREDICT, 16'hFFFF, 16'd0);
      issue_word(ndp_pkg::FUNC_PREDICT, 16'h1234, 16'd0);
      // large positive step, sum wraps past 65535
      issue_word(ndp_pkg::FUNC_RECORD, 16'd7, 16'hFFFF);
      issue_word(ndp_pkg::FUNC_PREDICT, 16'd7, 16'd0);
      // large negative step, sum wraps below zero
      issue_word(ndp_pkg::FUNC_RECORD, 16'd9, 16'h0000);
      issue_word(ndp_pkg::FUNC_PREDICT, 16'd9, 16'd0);
      // negative mean with remainder: steps -5 and -2 give -3, not -4
      issue_word(ndp_pkg::FUNC_RECORD, 16'd17, 16'd9);
      issue_word(ndp_pkg::FUNC_RECORD, 16'd13, 16'd4);
      issue_word(ndp_pkg::FUNC_RECORD, 16'd13, 16'd2);
      issue_word(ndp_pkg::FUNC_PREDICT, 16'd13, 16'hAAAA);
      issue_word(ndp_pkg::FUNC_PREDICT, 16'd17, 16'h5555);
      // several matches of one private port across the history
      issue_word(ndp_pkg::FUNC_RECORD, 16'd5, 16'd3);
      issue_word(ndp_pkg::FUNC_RECORD, 16'h0000, 16'hFFFF);
      issue_word(ndp_pkg::FUNC_RECORD, 16'd5, 16'h8000);
      issue_word(ndp_pkg::FUNC_PREDICT, 16'd5, 16'd0);
      issue_word(ndp_pkg::FUNC_PREDICT, 16'h0000, 16'd0);

      // random part in four idling phases; the table fills in the first half or so
      // and later records exercise the full-table drop
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
            default: begin send_idle_pct = 28; recv_stall_pct = 28; end
         endcase
         while (counted < 21 + RANDOM_ITEMS * (phase + 1) / 4) random_word();
      end
      req_bus.valid <= 1'b0;

      // drain: all predictions answered, then room for anything stray
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
